// ----- sv/pfdc_pkg.sv -----
// ----------------------------------------------------------------------------
// pfdc_pkg
// shared constants, types and command/status structs for the pll feedback
// divider codec
// ----------------------------------------------------------------------------
package pfdc_pkg;

	// largest multiplier that the lfsr sequence covers
	localparam int unsigned MSEL_MAX = 32768;

	// field widths
	localparam int unsigned M_W     = 16;
	localparam int unsigned CODE_W  = 17;
	localparam int unsigned PROP_W  = 5;
	localparam int unsigned INTEG_W = 7;

	// step counter holds MSEL_MAX + 1
	localparam int unsigned CNT_W = $clog2(MSEL_MAX + 2);

	// divider for the mid-range integral selector: 1024 / (m + 9)
	localparam int unsigned DIVIDEND = 1024;
	localparam int unsigned DIV_ADD  = 9;
	localparam int unsigned REM_W    = $clog2(DIVIDEND + 1);
	localparam int unsigned D_W      = 9;
	localparam int unsigned Q_W      = 4;

	// codes
	localparam logic [CODE_W-1:0] SEED     = CODE_W'(17'h04000);
	localparam logic [CODE_W-1:0] CODE_ONE = CODE_W'(17'h18003);
	localparam logic [CODE_W-1:0] CODE_TWO = CODE_W'(17'h10003);

	// selector thresholds
	localparam logic [M_W-1:0] INTEG_T1   = M_W'(16384);
	localparam logic [M_W-1:0] INTEG_T2   = M_W'(8192);
	localparam logic [M_W-1:0] INTEG_T3   = M_W'(2048);
	localparam logic [M_W-1:0] INTEG_T4   = M_W'(501);
	localparam logic [M_W-1:0] LOW_LIMIT  = M_W'(60);
	localparam logic [M_W-1:0] LOW_MASK   = M_W'(16'h003c);
	localparam logic [PROP_W-1:0] PROP_MAX = PROP_W'(31);

	// operation kinds
	localparam logic KIND_ENCODE = 1'b0;
	localparam logic KIND_DECODE = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic div_step;
		logic lfsr_step;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
		logic lfsr_done;
	} status_t;

endpackage

// ----- sv/pll_feedback_divider_codec_top.sv -----
// sequence: load, then d divider steps, then s lfsr steps, then the output register;
//   d up to 14, only for multipliers 60..500, s up to MSEL_MAX + 1
// words pass one at a time through the single shared lfsr stepper; the next
// word is taken once the last waits in the output register, not before
// reset: arst_n clears the controller state and the output valid flag;
//   no memories, no clearing pass
// ----------------------------------------------------------------------------
// pll_feedback_divider_codec_top
// converts a pll feedback multiplier to and from its scrambled 17-bit code
// and gives the loop filter selectors on encode
// ----------------------------------------------------------------------------
module pll_feedback_divider_codec_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            kind,
	input  logic [pfdc_pkg::M_W-1:0]        multiplier,
	input  logic [pfdc_pkg::CODE_W-1:0]     code_in,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [pfdc_pkg::CODE_W-1:0]     code_out,
	output logic [pfdc_pkg::PROP_W-1:0]     prop_select,
	output logic [pfdc_pkg::INTEG_W-1:0]    integ_select,
	output logic [pfdc_pkg::M_W-1:0]        multiplier_out,
	output logic                            found
);

	pfdc_pkg::cmd_t    cmd;
	pfdc_pkg::status_t status;

	// sequencer
	pfdc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath
	pfdc_datapath u_datapath (
		.clk            (clk),
		.cmd            (cmd),
		.status         (status),
		.kind           (kind),
		.multiplier     (multiplier),
		.code_in        (code_in),
		.code_out       (code_out),
		.prop_select    (prop_select),
		.integ_select   (integ_select),
		.multiplier_out (multiplier_out),
		.found          (found)
	);

endmodule

// ----- sv/pfdc_ctrl.sv -----
// ----------------------------------------------------------------------------
// pfdc_ctrl
// sequencer: takes a word, runs the divider, then the lfsr stepper, then
// hands the result to the output register
// ----------------------------------------------------------------------------
module pfdc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  pfdc_pkg::status_t status,
	output pfdc_pkg::cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DIV  = 4'b0010,
		S_LFSR = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;

	// output register can take a word when empty or being drained
	assign out_free = !out_valid_q || !out_stall;

	// next state and commands
	always_comb begin
		state_nxt     = state_q;
		cmd           = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_DIV;
				end
			end
			S_DIV: begin
				if (status.div_done) begin
					state_nxt = S_LFSR;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_LFSR: begin
				if (status.lfsr_done) begin
					state_nxt = S_DONE;
				end else begin
					cmd.lfsr_step = 1'b1;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// an accepted word always starts the divider phase
	a_load_to_div: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_DIV))
		else $error("accepted word did not start the divider phase");

	// a new result only appears after the sequence finished
	a_valid_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == S_DONE))
		else $error("output valid rose without a finished word");

	// the stepper never moves past its end condition
	a_no_overstep: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.lfsr_step |-> !status.lfsr_done)
		else $error("lfsr stepped after reaching its end");

	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> !cmd.out_load)
		else $error("output register overwritten while stalled");

endmodule

// ----- sv/pfdc_datapath.sv -----
// ----------------------------------------------------------------------------
// pfdc_datapath
// operand registers, shared lfsr stepper, subtract-and-count divider for the
// integral selector, and the output register
// ----------------------------------------------------------------------------
module pfdc_datapath (
	input  logic                                 clk,
	input  pfdc_pkg::cmd_t                       cmd,
	output pfdc_pkg::status_t                    status,
	input  logic                                 kind,
	input  logic [pfdc_pkg::M_W-1:0]             multiplier,
	input  logic [pfdc_pkg::CODE_W-1:0]          code_in,
	output logic [pfdc_pkg::CODE_W-1:0]          code_out,
	output logic [pfdc_pkg::PROP_W-1:0]          prop_select,
	output logic [pfdc_pkg::INTEG_W-1:0]         integ_select,
	output logic [pfdc_pkg::M_W-1:0]             multiplier_out,
	output logic                                 found
);

	// operand and working registers
	logic                           kind_q;
	logic [pfdc_pkg::M_W-1:0]       m_q;
	logic [pfdc_pkg::CODE_W-1:0]    c_q;
	logic [pfdc_pkg::CODE_W-1:0]    x_q;
	logic [pfdc_pkg::CNT_W-1:0]     cnt_q;
	logic [pfdc_pkg::REM_W-1:0]     rem_q;
	logic [pfdc_pkg::Q_W-1:0]       quo_q;
	logic [pfdc_pkg::D_W-1:0]       d_q;
	logic                           div_act_q;

	// output registers
	logic [pfdc_pkg::CODE_W-1:0]    code_out_q;
	logic [pfdc_pkg::PROP_W-1:0]    prop_q;
	logic [pfdc_pkg::INTEG_W-1:0]   integ_q;
	logic [pfdc_pkg::M_W-1:0]       mult_out_q;
	logic                           found_q;

	// load-time values
	logic [pfdc_pkg::CNT_W-1:0]     cnt_init;
	logic                           div_act_init;

	// step values and result logic
	logic [pfdc_pkg::CODE_W-1:0]    enc_next;
	logic [pfdc_pkg::CODE_W-1:0]    dec_next;
	logic [pfdc_pkg::CODE_W-1:0]    enc_code;
	logic [pfdc_pkg::PROP_W-1:0]    prop_val;
	logic [pfdc_pkg::INTEG_W-1:0]   integ_val;
	logic [pfdc_pkg::INTEG_W-1:0]   div_integ;
	logic [pfdc_pkg::M_W-1:0]       dec_mult;

	// step count at load
	always_comb begin
		cnt_init = '0;
		if (kind == pfdc_pkg::KIND_ENCODE) begin
			if (multiplier > pfdc_pkg::M_W'(2) &&
			    32'(multiplier) <= pfdc_pkg::MSEL_MAX) begin
				cnt_init = pfdc_pkg::CNT_W'(pfdc_pkg::MSEL_MAX + 32'd1 - 32'(multiplier));
			end
		end else if (code_in != pfdc_pkg::CODE_ONE && code_in != pfdc_pkg::CODE_TWO) begin
			cnt_init = pfdc_pkg::CNT_W'(pfdc_pkg::MSEL_MAX + 32'd1);
		end
	end

	assign div_act_init = (kind == pfdc_pkg::KIND_ENCODE) &&
		(multiplier >= pfdc_pkg::LOW_LIMIT) && (multiplier < pfdc_pkg::INTEG_T4);

	// one lfsr step in each direction
	assign enc_next = {2'b00, x_q[0] ^ x_q[1], x_q[14:1]};
	assign dec_next = {2'b00, x_q[13:0], x_q[0] ^ x_q[14]};

	// status back to the controller
	assign status.div_done  = !div_act_q || (rem_q < pfdc_pkg::REM_W'(d_q));
	assign status.lfsr_done = (cnt_q == '0) ||
		((kind_q == pfdc_pkg::KIND_DECODE) && (x_q == pfdc_pkg::SEED));

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q    <= kind;
			m_q       <= multiplier;
			c_q       <= code_in;
			x_q       <= (kind == pfdc_pkg::KIND_ENCODE) ? pfdc_pkg::SEED : code_in;
			cnt_q     <= cnt_init;
			rem_q     <= pfdc_pkg::REM_W'(pfdc_pkg::DIVIDEND);
			quo_q     <= '0;
			d_q       <= pfdc_pkg::D_W'(multiplier + pfdc_pkg::M_W'(pfdc_pkg::DIV_ADD));
			div_act_q <= div_act_init;
		end
		if (cmd.div_step) begin
			rem_q <= rem_q - pfdc_pkg::REM_W'(d_q);
			quo_q <= quo_q + pfdc_pkg::Q_W'(1);
		end
		if (cmd.lfsr_step) begin
			x_q   <= (kind_q == pfdc_pkg::KIND_ENCODE) ? enc_next : dec_next;
			cnt_q <= cnt_q - pfdc_pkg::CNT_W'(1);
		end
	end

	// encode code with fixed small values
	always_comb begin
		if (m_q == pfdc_pkg::M_W'(0)) begin
			enc_code = '0;
		end else if (m_q == pfdc_pkg::M_W'(1)) begin
			enc_code = pfdc_pkg::CODE_ONE;
		end else if (m_q == pfdc_pkg::M_W'(2)) begin
			enc_code = pfdc_pkg::CODE_TWO;
		end else begin
			enc_code = x_q;
		end
	end

	// proportional selector
	assign prop_val = (m_q < pfdc_pkg::LOW_LIMIT) ?
		(pfdc_pkg::PROP_W'(m_q[5:1]) + pfdc_pkg::PROP_W'(1)) : pfdc_pkg::PROP_MAX;

	// divider quotient times four, with the quotient one higher when the division is exact
	assign div_integ = (rem_q == '0) ?
		pfdc_pkg::INTEG_W'({5'(quo_q) + 5'd1, 2'b00}) :
		pfdc_pkg::INTEG_W'({quo_q, 2'b00});

	// integral selector
	always_comb begin
		if (m_q > pfdc_pkg::INTEG_T1) begin
			integ_val = pfdc_pkg::INTEG_W'(1);
		end else if (m_q > pfdc_pkg::INTEG_T2) begin
			integ_val = pfdc_pkg::INTEG_W'(2);
		end else if (m_q > pfdc_pkg::INTEG_T3) begin
			integ_val = pfdc_pkg::INTEG_W'(4);
		end else if (m_q >= pfdc_pkg::INTEG_T4) begin
			integ_val = pfdc_pkg::INTEG_W'(8);
		end else if (m_q >= pfdc_pkg::LOW_LIMIT) begin
			integ_val = div_integ;
		end else begin
			integ_val = pfdc_pkg::INTEG_W'(m_q & pfdc_pkg::LOW_MASK) + pfdc_pkg::INTEG_W'(4);
		end
	end

	// decoded multiplier: remaining count, zero when out of range
	always_comb begin
		if (c_q == pfdc_pkg::CODE_ONE) begin
			dec_mult = pfdc_pkg::M_W'(1);
		end else if (c_q == pfdc_pkg::CODE_TWO) begin
			dec_mult = pfdc_pkg::M_W'(2);
		end else if (32'(cnt_q) > pfdc_pkg::MSEL_MAX) begin
			dec_mult = '0;
		end else begin
			dec_mult = pfdc_pkg::M_W'(cnt_q);
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (kind_q == pfdc_pkg::KIND_ENCODE) begin
				code_out_q <= enc_code;
				prop_q     <= prop_val;
				integ_q    <= integ_val;
				mult_out_q <= '0;
				found_q    <= 1'b1;
			end else begin
				code_out_q <= '0;
				prop_q     <= '0;
				integ_q    <= '0;
				mult_out_q <= dec_mult;
				found_q    <= (dec_mult != '0);
			end
		end
	end

	assign code_out       = code_out_q;
	assign prop_select    = prop_q;
	assign integ_select   = integ_q;
	assign multiplier_out = mult_out_q;
	assign found          = found_q;

endmodule

// ----- sim/pll_feedback_divider_codec_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pll_feedback_divider_codec_top_tb
// self-checking bench for the feedback divider codec: encode and decode words
// go through the valid/stall channels with random idling on both sides, and
// every output word is checked against a predictor of the lfsr codec and the
// loop filter selectors
// ----------------------------------------------------------------------------
module pll_feedback_divider_codec_top_tb;

	localparam int unsigned CYCLE_LIMIT = 20_000_000;
	localparam int unsigned RAND_WORDS  = 100;
	localparam int unsigned TAIL_CYCLES = 64;
	// window at the top of the multiplier range where the lfsr runs short
	localparam int unsigned NEAR_TOP    = 400;

	typedef struct packed {
		logic [pfdc_pkg::CODE_W-1:0]  code;
		logic [pfdc_pkg::PROP_W-1:0]  prop;
		logic [pfdc_pkg::INTEG_W-1:0] integ;
		logic [pfdc_pkg::M_W-1:0]     mult;
		logic                         found;
	} codec_word_t;

	// expected output words and the codec predictor
	class feedback_code_board;
		codec_word_t expected_words[$];
		int unsigned errors;
		int unsigned encodes;
		int unsigned decodes;
		int unsigned misses;

		function new();
			errors  = 0;
			encodes = 0;
			decodes = 0;
			misses  = 0;
		endfunction

		// forward lfsr from the seed, one step per count from m up to the maximum
		function logic [pfdc_pkg::CODE_W-1:0] lfsr_code_of(int unsigned m);
			int unsigned x;
			int unsigned i;
			x = 32'(pfdc_pkg::SEED);
			if (m == 0) return '0;
			if (m == 1) return pfdc_pkg::CODE_ONE;
			if (m == 2) return pfdc_pkg::CODE_TWO;
			for (i = m; i <= pfdc_pkg::MSEL_MAX; i++) begin
				x = (((x ^ (x >> 1)) & 32'h1) << 14) | ((x >> 1) & 32'hffff);
			end
			return x[pfdc_pkg::CODE_W-1:0];
		endfunction

		// reverse lfsr back to the seed; 0 when the seed is never reached
		function int unsigned lfsr_multiplier_of(logic [pfdc_pkg::CODE_W-1:0] c);
			int unsigned x;
			int unsigned left;
			x    = 32'(c);
			left = pfdc_pkg::MSEL_MAX + 1;
			if (c == pfdc_pkg::CODE_ONE) return 1;
			if (c == pfdc_pkg::CODE_TWO) return 2;
			while (x != 32'(pfdc_pkg::SEED) && left > 0) begin
				x = ((x ^ (x >> 14)) & 32'h1) | ((x << 1) & 32'h7fff);
				left--;
			end
			if (left > pfdc_pkg::MSEL_MAX) return 0;
			return left;
		endfunction

		function int unsigned prop_of(int unsigned m);
			if (m < 32'(pfdc_pkg::LOW_LIMIT)) return (m >> 1) + 1;
			return 32'(pfdc_pkg::PROP_MAX);
		endfunction

		function int unsigned integ_of(int unsigned m);
			int unsigned d;
			int unsigned q;
			if (m > 32'(pfdc_pkg::INTEG_T1)) return 1;
			if (m > 32'(pfdc_pkg::INTEG_T2)) return 2;
			if (m > 32'(pfdc_pkg::INTEG_T3)) return 4;
			if (m >= 32'(pfdc_pkg::INTEG_T4)) return 8;
			if (m >= 32'(pfdc_pkg::LOW_LIMIT)) begin
				d = m + pfdc_pkg::DIV_ADD;
				q = pfdc_pkg::DIVIDEND / d;
				return (q * d == pfdc_pkg::DIVIDEND) ? (q + 1) * 4 : q * 4;
			end
			return (m & 32'(pfdc_pkg::LOW_MASK)) + 4;
		endfunction

		// accepted input word: work out what comes back
		function void note_word(logic k, logic [pfdc_pkg::M_W-1:0] m,
			logic [pfdc_pkg::CODE_W-1:0] c);
			codec_word_t w;
			int unsigned r;
			w = '0;
			if (k == pfdc_pkg::KIND_ENCODE) begin
				w.code  = lfsr_code_of(32'(m));
				w.prop  = pfdc_pkg::PROP_W'(prop_of(32'(m)));
				w.integ = pfdc_pkg::INTEG_W'(integ_of(32'(m)));
				w.found = 1'b1;
				encodes++;
			end else begin
				r       = lfsr_multiplier_of(c);
				w.mult  = pfdc_pkg::M_W'(r);
				w.found = (r != 0);
				decodes++;
				if (r == 0) misses++;
			end
			expected_words.push_back(w);
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		// output word against the oldest expectation, field by field
		task check_word(codec_word_t got);
			codec_word_t exp_w;
			if (expected_words.size() == 0) begin
				report("output word with nothing expected");
				return;
			end
			exp_w = expected_words.pop_front();
			if (got.code !== exp_w.code)
				report($sformatf("code_out %h, wanted %h", got.code, exp_w.code));
			if (got.prop !== exp_w.prop)
				report($sformatf("prop_select %0d, wanted %0d", got.prop, exp_w.prop));
			if (got.integ !== exp_w.integ)
				report($sformatf("integ_select %0d, wanted %0d", got.integ, exp_w.integ));
			if (got.mult !== exp_w.mult)
				report($sformatf("multiplier_out %0d, wanted %0d", got.mult, exp_w.mult));
			if (got.found !== exp_w.found)
				report($sformatf("found %b, wanted %b", got.found, exp_w.found));
		endtask
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic                          kind;
	logic [pfdc_pkg::M_W-1:0]      multiplier;
	logic [pfdc_pkg::CODE_W-1:0]   code_in;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [pfdc_pkg::CODE_W-1:0]   code_out;
	logic [pfdc_pkg::PROP_W-1:0]   prop_select;
	logic [pfdc_pkg::INTEG_W-1:0]  integ_select;
	logic [pfdc_pkg::M_W-1:0]      multiplier_out;
	logic                          found;

	feedback_code_board board;
	bit                 calm;
	int unsigned        cycles = 0;

	pll_feedback_divider_codec_top u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.multiplier     (multiplier),
		.code_in        (code_in),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.code_out       (code_out),
		.prop_select    (prop_select),
		.integ_select   (integ_select),
		.multiplier_out (multiplier_out),
		.found          (found)
	);

	// clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// output side: random stall, check each accepted word
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_word('{code_out, prop_select, integ_select, multiplier_out, found});
		out_stall <= calm ? 1'b0 : ($urandom_range(99) < 20);
	end

	// present one word, hold it until taken
	task send_word(logic k, logic [pfdc_pkg::M_W-1:0] m, logic [pfdc_pkg::CODE_W-1:0] c);
		while (!calm && $urandom_range(99) < 20) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		kind       <= k;
		multiplier <= m;
		code_in    <= c;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_word(k, m, c);
	endtask

	task send_encode(int unsigned m);
		send_word(pfdc_pkg::KIND_ENCODE, pfdc_pkg::M_W'(m),
			pfdc_pkg::CODE_W'($urandom_range(0, 17'h1ffff)));
	endtask

	task send_decode(logic [pfdc_pkg::CODE_W-1:0] c);
		send_word(pfdc_pkg::KIND_DECODE, pfdc_pkg::M_W'($urandom_range(0, 16'hffff)), c);
	endtask

	// random word: mostly cheap near-top multipliers and their codes, a few slow ones
	task send_random_word();
		int unsigned r;
		int unsigned m;
		logic [pfdc_pkg::CODE_W-1:0] c;
		r = $urandom_range(99);
		m = $urandom_range(pfdc_pkg::MSEL_MAX - NEAR_TOP, pfdc_pkg::MSEL_MAX);
		if (r < 4) begin
			send_encode($urandom_range(3, 32'(pfdc_pkg::INTEG_T3)));
		end else if (r < 8) begin
			send_decode(pfdc_pkg::CODE_W'($urandom_range(0, 17'h1ffff)));
		end else if (r < 10) begin
			if ($urandom_range(1))
				send_encode($urandom_range(0, 2));
			else
				send_decode($urandom_range(1) ? pfdc_pkg::CODE_ONE : pfdc_pkg::CODE_TWO);
		end else if (r < 40) begin
			send_encode(m);
		end else if (r < 55) begin
			send_encode($urandom_range(pfdc_pkg::MSEL_MAX + 1, 16'hffff));
		end else begin
			c = board.lfsr_code_of(m);
			// broken codes: stray high bits, or one flipped low bit
			if ($urandom_range(5) == 0) begin
				if ($urandom_range(1))
					c = c | pfdc_pkg::CODE_W'($urandom_range(1, 3) << 15);
				else
					c = c ^ pfdc_pkg::CODE_W'(1 << $urandom_range(0, 14));
			end
			send_decode(c);
		end
	endtask

	// stimulus
	initial begin
		int unsigned enc_dir[18];
		int unsigned i;
		enc_dir    = '{0, 1, 2, 3, 59, 60, 61, 500, 501, 2048, 2049,
			8192, 8193, 16384, 16385, 32768, 32769, 65535};
		board      = new();
		calm       = 1'b0;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		kind       <= pfdc_pkg::KIND_ENCODE;
		multiplier <= '0;
		code_in    <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// selector thresholds, fixed codes and the ends of the multiplier range
		foreach (enc_dir[j]) send_encode(enc_dir[j]);
		// fixed codes, the seed, a code that never matches, stray high bits, two valid codes
		send_decode(pfdc_pkg::CODE_ONE);
		send_decode(pfdc_pkg::CODE_TWO);
		send_decode(pfdc_pkg::SEED);
		send_decode('0);
		send_decode(17'h1ffff);
		send_decode(board.lfsr_code_of(pfdc_pkg::MSEL_MAX));
		send_decode(board.lfsr_code_of(pfdc_pkg::MSEL_MAX - 768));

		for (i = 0; i < RAND_WORDS; i++) begin
			calm = (i >= 30 && i < 60);
			send_random_word();
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		while (board.expected_words.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d encode and %0d decode words, %0d codes not found",
			board.encodes, board.decodes, board.misses);
		$display("mismatches: %0d, cycles: %0d", board.errors, cycles);
		if (board.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
